// ===== sv/rek_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rek_pkg;

    localparam int COUNT_BITS_DEFAULT = 16;

    localparam logic [7:0]  BOOL_EDIT_CODE   = 8'h11;
    localparam logic [7:0]  EDIT_MODE_RESET  = 8'h00;
    localparam logic [15:0] LONG_PRESS_RESET = 16'd3000;

    localparam int CFG_DATA_W = 16;

    localparam logic CFG_EDIT_MODE  = 1'b0;
    localparam logic CFG_LONG_PRESS = 1'b1;

    localparam logic [2:0] KEY_LEFT  = 3'd0;
    localparam logic [2:0] KEY_UP    = 3'd1;
    localparam logic [2:0] KEY_DOWN  = 3'd2;
    localparam logic [2:0] KEY_RIGHT = 3'd3;
    localparam logic [2:0] KEY_MENU  = 3'd4;
    localparam logic [2:0] KEY_ENTER = 3'd5;

    typedef enum logic [1:0] {
        PHASE_RELEASED = 2'd0,
        PHASE_COUNTING = 2'd1,
        PHASE_LONG     = 2'd2
    } phase_t;

    typedef struct packed {
        logic pin_a;
        logic pin_b;
        logic button_level;
    } rek_in_t;

    typedef struct packed {
        logic       key_valid;
        logic [2:0] key_code;
        logic       rotation_mark;
    } rek_out_t;

    typedef struct packed {
        logic [7:0]  edit_mode;
        logic [15:0] long_press_ticks;
    } rek_cfg_t;

endpackage

`default_nettype wire

// ===== sv/rek_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rek_decode
    import rek_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     advance,
    input  wire rek_in_t  sample,
    input  wire rek_cfg_t cfg,
    output rek_out_t      result
);

    localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    logic [2:0]            prev_sample_reg;
    logic [2:0]            prev_sample_next;
    phase_t                phase_reg;
    phase_t                phase_next;
    logic [COUNT_BITS-1:0] ticks_reg;
    logic [COUNT_BITS-1:0] ticks_next;

    logic                  nav_mode;
    logic                  a_fall;
    logic                  btn_fall;
    logic [COUNT_BITS-1:0] ticks_inc;
    logic                  long_hit;
    logic                  short_release;
    logic                  release_event;

    assign nav_mode  = (cfg.edit_mode == '0);
    assign a_fall    = prev_sample_reg[0] && !sample.pin_a;
    assign btn_fall  = prev_sample_reg[2] && !sample.button_level;
    assign ticks_inc = (ticks_reg == '1) ? ticks_reg : ticks_reg + 1'b1;
    assign long_hit  = CMP_W'(ticks_inc) > CMP_W'(cfg.long_press_ticks);
    assign short_release = CMP_W'(ticks_reg) < CMP_W'(cfg.long_press_ticks);
    assign release_event = (phase_reg != PHASE_RELEASED) && (ticks_reg != '0);

    assign prev_sample_next = {sample.button_level, sample.pin_b, sample.pin_a};

    always_comb begin
        phase_next = phase_reg;
        if (nav_mode) begin
            if (!sample.button_level) begin
                case (phase_reg)
                    PHASE_RELEASED: begin
                        if (btn_fall) begin
                            phase_next = PHASE_COUNTING;
                        end
                    end
                    PHASE_COUNTING: begin
                        if (long_hit) begin
                            phase_next = PHASE_LONG;
                        end
                    end
                    default: begin
                        phase_next = phase_reg;
                    end
                endcase
            end else if (release_event) begin
                phase_next = PHASE_RELEASED;
            end
        end
    end

    always_comb begin
        ticks_next = ticks_reg;
        result     = '0;
        if (nav_mode) begin
            if (!sample.button_level) begin
                case (phase_reg)
                    PHASE_RELEASED: begin
                        if (btn_fall) begin
                            ticks_next = '0;
                        end
                    end
                    PHASE_COUNTING: begin
                        ticks_next = ticks_inc;
                        if (long_hit) begin
                            result.key_valid = 1'b1;
                            result.key_code  = KEY_MENU;
                        end
                    end
                    default: begin
                        ticks_next = ticks_inc;
                    end
                endcase
            end else if (release_event) begin
                ticks_next = '0;
                if (short_release) begin
                    result.key_valid = 1'b1;
                    result.key_code  = KEY_ENTER;
                end
            end else if (a_fall) begin
                result.key_valid = 1'b1;
                result.key_code  = sample.pin_b ? KEY_DOWN : KEY_UP;
            end
        end else begin
            if (btn_fall) begin
                result.key_valid = 1'b1;
                result.key_code  = KEY_ENTER;
            end else if (a_fall) begin
                result.key_valid     = 1'b1;
                result.key_code      = sample.pin_b ? KEY_LEFT : KEY_RIGHT;
                result.rotation_mark = (cfg.edit_mode != BOOL_EDIT_CODE);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_sample_reg <= '0;
            phase_reg       <= PHASE_RELEASED;
            ticks_reg       <= '0;
        end else if (advance) begin
            prev_sample_reg <= prev_sample_next;
            phase_reg       <= phase_next;
            ticks_reg       <= ticks_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/rotary_encoder_key_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Key decoder for a rotary encoder with a push button. Every accepted transaction is one
// sample of pins A and B and the active-low button, and it produces exactly one result
// transaction with the key event, if any, for that tick. One transaction is taken per clock
// cycle while m_ready does not stall the output. A sample is held in the input register, the
// whole decode is combinational between the input and result registers, and its result is
// offered on m_valid from the result register. The edit_mode and long_press_ticks registers
// are written through the configuration port; the user must write them only while no
// transaction is in flight, as the block itself does not enforce this.

module rotary_encoder_key_decoder
    import rek_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire rek_in_t               s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output rek_out_t                   m_data,
    input  wire logic                  cfg_wr_en,
    input  wire logic                  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    rek_cfg_t cfg_reg;
    logic     in_valid_reg;
    rek_in_t  in_data_reg;
    logic     out_valid_reg;
    rek_out_t out_data_reg;
    rek_out_t decode_result;
    logic     advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    rek_decode #(
        .COUNT_BITS(COUNT_BITS)
    ) u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .sample  (in_data_reg),
        .cfg     (cfg_reg),
        .result  (decode_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.edit_mode        <= EDIT_MODE_RESET;
            cfg_reg.long_press_ticks <= LONG_PRESS_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_EDIT_MODE:  cfg_reg.edit_mode        <= cfg_wdata[7:0];
                CFG_LONG_PRESS: cfg_reg.long_press_ticks <= cfg_wdata[15:0];
                default:        cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= decode_result;
        end
    end

endmodule

`default_nettype wire
